@@ rtl/grouped_team_queue_defines.svh @@
// Assertion macros for the port checker of the grouped team queue.
`ifndef GROUPED_TEAM_QUEUE_DEFINES_SVH
`define GROUPED_TEAM_QUEUE_DEFINES_SVH

// Implication checked on the same edge.
`define GTQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked on the next edge.
`define GTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/gtq_pkg.sv @@
// Package of the grouped team queue: sizes, codes, state and command types.
package gtq_pkg;

    localparam int MEMBER_ID_BITS = 12;
    localparam int MAX_TEAMS      = 1024;
    localparam int NODE_CAPACITY  = 1024;

    localparam int MEMBER_FIELD_W = 12;
    localparam int TEAM_FIELD_W   = 10;
    localparam int MEMBER_COUNT   = 1 << MEMBER_ID_BITS;
    localparam int TEAM_BITS      = (MAX_TEAMS > 1) ? $clog2(MAX_TEAMS) : 1;
    localparam int NODE_BITS      = $clog2(NODE_CAPACITY);
    localparam int USED_BITS      = NODE_BITS + 1;

    localparam int SWEEP_A        = (MEMBER_COUNT > MAX_TEAMS) ? MEMBER_COUNT : MAX_TEAMS;
    localparam int SWEEP_COUNT    = (SWEEP_A > NODE_CAPACITY) ? SWEEP_A : NODE_CAPACITY;
    localparam int SWEEP_BITS     = $clog2(SWEEP_COUNT) + 1;

    typedef enum logic [1:0] {
        FUNC_ASSIGN  = 2'd0,
        FUNC_ENQUEUE = 2'd1,
        FUNC_DEQUEUE = 2'd2,
        FUNC_CLEAR   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ASSIGN,
        S_ENQ0,
        S_ENQ1,
        S_ENQ2,
        S_DEQ0,
        S_DEQ1,
        S_DEQ2,
        S_DEQ3
    } t_state;

    typedef struct packed {
        logic latch;
        logic sweep;
        logic assign_wr;
        logic enq_take;
        logic enq_wr;
        logic deq_sel;
        logic deq_take;
        logic deq_wr;
        logic emit_full;
        logic emit_empty;
    } t_dp_cmd;

    typedef struct packed {
        logic sweep_done;
        logic full;
        logic empty;
        logic out_free;
    } t_dp_stat;

endpackage

@@ rtl/gtq_ctrl.sv @@
// Controller state machine of the grouped team queue.
module gtq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_func,
    input  gtq_pkg::t_dp_stat i_stat,
    output logic             o_in_ready,
    output gtq_pkg::t_dp_cmd o_cmd
);

    gtq_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gtq_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            gtq_pkg::S_CLEAR: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_done) begin
                    n_state = gtq_pkg::S_IDLE;
                end
            end
            gtq_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    unique case (gtq_pkg::t_func'(i_func))
                        gtq_pkg::FUNC_ASSIGN:  n_state = gtq_pkg::S_ASSIGN;
                        gtq_pkg::FUNC_ENQUEUE: n_state = gtq_pkg::S_ENQ0;
                        gtq_pkg::FUNC_DEQUEUE: n_state = gtq_pkg::S_DEQ0;
                        gtq_pkg::FUNC_CLEAR:   n_state = gtq_pkg::S_CLEAR;
                        default:               n_state = gtq_pkg::S_IDLE;
                    endcase
                end
            end
            gtq_pkg::S_ASSIGN: begin
                o_cmd.assign_wr = 1'b1;
                n_state = gtq_pkg::S_IDLE;
            end
            gtq_pkg::S_ENQ0: begin
                if (!i_stat.full) begin
                    n_state = gtq_pkg::S_ENQ1;
                end else if (i_stat.out_free) begin
                    o_cmd.emit_full = 1'b1;
                    n_state = gtq_pkg::S_IDLE;
                end
            end
            gtq_pkg::S_ENQ1: begin
                o_cmd.enq_take = 1'b1;
                n_state = gtq_pkg::S_ENQ2;
            end
            gtq_pkg::S_ENQ2: begin
                o_cmd.enq_wr = 1'b1;
                n_state = gtq_pkg::S_IDLE;
            end
            gtq_pkg::S_DEQ0: begin
                if (!i_stat.empty) begin
                    n_state = gtq_pkg::S_DEQ1;
                end else if (i_stat.out_free) begin
                    o_cmd.emit_empty = 1'b1;
                    n_state = gtq_pkg::S_IDLE;
                end
            end
            gtq_pkg::S_DEQ1: begin
                o_cmd.deq_sel = 1'b1;
                n_state = gtq_pkg::S_DEQ2;
            end
            gtq_pkg::S_DEQ2: begin
                o_cmd.deq_sel  = 1'b1;
                o_cmd.deq_take = 1'b1;
                n_state = gtq_pkg::S_DEQ3;
            end
            gtq_pkg::S_DEQ3: begin
                if (i_stat.out_free) begin
                    o_cmd.deq_wr = 1'b1;
                    n_state = gtq_pkg::S_IDLE;
                end
            end
            default: n_state = gtq_pkg::S_CLEAR;
        endcase
    end

endmodule

@@ rtl/gtq_datapath.sv @@
// Datapath of the grouped team queue: tables, node pool, pointers, result register.
module gtq_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  gtq_pkg::t_dp_cmd                   i_cmd,
    input  logic [gtq_pkg::MEMBER_FIELD_W-1:0] i_member_id,
    input  logic [gtq_pkg::TEAM_FIELD_W-1:0]   i_team,
    input  logic                               i_out_ready,
    output gtq_pkg::t_dp_stat                  o_stat,
    output logic                               o_out_valid,
    output logic [gtq_pkg::MEMBER_FIELD_W-1:0] o_member_out,
    output logic [1:0]                         o_status
);

    localparam int MB = gtq_pkg::MEMBER_ID_BITS;
    localparam int TB = gtq_pkg::TEAM_BITS;
    localparam int NB = gtq_pkg::NODE_BITS;
    localparam int UB = gtq_pkg::USED_BITS;
    localparam int SB = gtq_pkg::SWEEP_BITS;
    localparam int FW = gtq_pkg::TEAM_FIELD_W;

    logic [FW-1:0] r_tom    [gtq_pkg::MEMBER_COUNT];
    logic          r_ne     [gtq_pkg::MAX_TEAMS];
    logic [NB-1:0] r_head   [gtq_pkg::MAX_TEAMS];
    logic [NB-1:0] r_tail   [gtq_pkg::MAX_TEAMS];
    logic [TB-1:0] r_ring   [gtq_pkg::MAX_TEAMS];
    logic [MB-1:0] r_nmem   [gtq_pkg::NODE_CAPACITY];
    logic [NB-1:0] r_nnext  [gtq_pkg::NODE_CAPACITY];
    logic [NB-1:0] r_flist  [gtq_pkg::NODE_CAPACITY];

    logic [FW-1:0] r_tom_q;
    logic          r_ne_q;
    logic [NB-1:0] r_head_q, r_tail_q;
    logic [TB-1:0] r_ring_q;
    logic [MB-1:0] r_nmem_q;
    logic [NB-1:0] r_nnext_q, r_flist_q;

    logic [MB-1:0] r_mem;
    logic [FW-1:0] r_team;
    logic [TB-1:0] r_t;
    logic [NB-1:0] r_n;
    logic          r_last;
    logic [TB-1:0] r_rd, r_wr;
    logic [UB-1:0] r_used;
    logic [SB-1:0] r_cnt;
    logic          r_ov;
    logic [gtq_pkg::MEMBER_FIELD_W-1:0] r_om;
    logic [1:0]    r_os;

    logic [TB-1:0] w_tom_t, w_t_rd;
    logic [UB-1:0] w_used_m1;
    logic          w_sweep_last;
    logic [TB-1:0] w_wr_next, w_rd_next;

    assign w_tom_t   = ({1'b0, r_tom_q} < (FW+1)'(gtq_pkg::MAX_TEAMS)) ? TB'(r_tom_q) : '0;
    assign w_t_rd    = i_cmd.deq_sel ? r_ring_q : w_tom_t;
    assign w_used_m1 = r_used - UB'(1);
    assign w_sweep_last = (r_cnt == SB'(gtq_pkg::SWEEP_COUNT - 1));
    assign w_wr_next = (r_wr == TB'(gtq_pkg::MAX_TEAMS - 1)) ? '0 : r_wr + TB'(1);
    assign w_rd_next = (r_rd == TB'(gtq_pkg::MAX_TEAMS - 1)) ? '0 : r_rd + TB'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep && r_cnt < SB'(gtq_pkg::MEMBER_COUNT)) begin
            r_tom[r_cnt[MB-1:0]] <= '0;
        end else if (i_cmd.assign_wr &&
                     {1'b0, r_team} < (FW+1)'(gtq_pkg::MAX_TEAMS)) begin
            r_tom[r_mem] <= r_team;
        end
        r_tom_q <= r_tom[r_mem];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep && r_cnt < SB'(gtq_pkg::MAX_TEAMS)) begin
            r_ne[r_cnt[TB-1:0]] <= 1'b0;
        end else if (i_cmd.enq_wr && !r_ne_q) begin
            r_ne[r_t] <= 1'b1;
        end else if (i_cmd.deq_wr && r_last) begin
            r_ne[r_t] <= 1'b0;
        end
        r_ne_q <= r_ne[w_t_rd];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.enq_wr && !r_ne_q) begin
            r_head[r_t] <= r_n;
        end else if (i_cmd.deq_wr && !r_last) begin
            r_head[r_t] <= r_nnext_q;
        end
        r_head_q <= r_head[w_t_rd];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.enq_wr) begin
            r_tail[r_t] <= r_n;
        end
        r_tail_q <= r_tail[w_t_rd];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.enq_wr && !r_ne_q) begin
            r_ring[r_wr] <= r_t;
        end
        r_ring_q <= r_ring[r_rd];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.enq_wr) begin
            r_nmem[r_n] <= r_mem;
        end
        r_nmem_q <= r_nmem[r_head_q];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.enq_wr && r_ne_q) begin
            r_nnext[r_tail_q] <= r_n;
        end
        r_nnext_q <= r_nnext[r_head_q];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep && r_cnt < SB'(gtq_pkg::NODE_CAPACITY)) begin
            r_flist[r_cnt[NB-1:0]] <= r_cnt[NB-1:0];
        end else if (i_cmd.deq_wr) begin
            r_flist[w_used_m1[NB-1:0]] <= r_n;
        end
        r_flist_q <= r_flist[r_used[NB-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mem  <= MB'(i_member_id);
            r_team <= i_team;
        end
        if (i_cmd.enq_take) begin
            r_t <= w_tom_t;
            r_n <= r_flist_q;
        end else if (i_cmd.deq_take) begin
            r_t    <= r_ring_q;
            r_n    <= r_head_q;
            r_last <= (r_head_q == r_tail_q);
        end
        if (r_ov && i_out_ready) begin
            r_om <= r_om;
        end
        if (i_cmd.emit_full || i_cmd.emit_empty) begin
            r_om <= '0;
            r_os <= i_cmd.emit_full ? 2'(gtq_pkg::ST_FULL) : 2'(gtq_pkg::ST_EMPTY);
        end else if (i_cmd.deq_wr) begin
            r_om <= gtq_pkg::MEMBER_FIELD_W'(r_nmem_q);
            r_os <= 2'(gtq_pkg::ST_OK);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_rd   <= '0;
            r_wr   <= '0;
            r_used <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (i_cmd.latch) begin
                r_cnt <= '0;
            end else if (i_cmd.sweep && !w_sweep_last) begin
                r_cnt <= r_cnt + SB'(1);
            end
            if (i_cmd.sweep) begin
                r_rd   <= '0;
                r_wr   <= '0;
                r_used <= '0;
            end else if (i_cmd.enq_wr) begin
                r_used <= r_used + UB'(1);
                if (!r_ne_q) begin
                    r_wr <= w_wr_next;
                end
            end else if (i_cmd.deq_wr) begin
                r_used <= w_used_m1;
                if (r_last) begin
                    r_rd <= w_rd_next;
                end
            end
            if (i_cmd.emit_full || i_cmd.emit_empty || i_cmd.deq_wr) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_stat.sweep_done = w_sweep_last;
    assign o_stat.full       = (r_used >= UB'(gtq_pkg::NODE_CAPACITY));
    assign o_stat.empty      = (r_used == '0);
    assign o_stat.out_free   = !r_ov || i_out_ready;
    assign o_out_valid  = r_ov;
    assign o_member_out = r_om;
    assign o_status     = r_os;

endmodule

@@ rtl/grouped_team_queue.sv @@
// Top level of the grouped team queue: stream ports around controller and datapath.
// Team queue with 4096 members, 1024 teams and a pool of 1024 queued members. After reset
// and after every clear-all item a clearing pass runs through the member table, team
// flags and free list while no item is accepted. One item is in work at a time: assign
// has a write state, enqueue a check, take and write state, dequeue a check, select,
// take and write state, set by the chain of dependent registered memory reads (member
// table, team pointers, node memory). Results wait in an output register; a dequeue or
// error finishes only once that register is free or being taken.
module grouped_team_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // member_id [11:0], team [21:12], zero [23:22]
    input  logic [1:0]  s_axis_tuser,   // func [1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // member_out [11:0], zero [15:12]
    output logic [1:0]  m_axis_tuser    // status [1:0]
);

    gtq_pkg::t_dp_cmd  w_cmd;
    gtq_pkg::t_dp_stat w_stat;
    logic [11:0]       w_member_out;

    gtq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_func     (s_axis_tuser),
        .i_stat     (w_stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    gtq_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_member_id  (s_axis_tdata[11:0]),
        .i_team       (s_axis_tdata[21:12]),
        .i_out_ready  (m_axis_tready),
        .o_stat       (w_stat),
        .o_out_valid  (m_axis_tvalid),
        .o_member_out (w_member_out),
        .o_status     (m_axis_tuser)
    );

    assign m_axis_tdata = {4'b0, w_member_out};

endmodule

@@ rtl/gtq_checker.sv @@
// Port checker of the grouped team queue and its bind.
`include "grouped_team_queue_defines.svh"

module gtq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    `GTQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
    `GTQ_ASSERT_NOW(a_status_code, i_clk, i_rst_n, m_axis_tvalid, m_axis_tuser != 2'd3, "bad status code")
    `GTQ_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser != 2'd0, m_axis_tdata == 16'd0, "error result with nonzero member")
    `GTQ_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second transfer while item in work")

endmodule

bind grouped_team_queue gtq_checker u_gtq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

@@ verif/team_queue_checker.sv @@
// Checker for the grouped team queue: watches both channels, predicts and compares results.
`timescale 1ns / 1ps
module team_queue_checker
    import gtq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [23:0] i_in_data,
    input  logic [1:0]  i_in_user,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_out_data,
    input  logic [1:0]  i_out_user,
    output int          o_errors,
    output int          o_pending
);
    typedef struct packed {
        logic [11:0] member;
        t_status     status;
    } t_dequeue_result;

    logic [9:0]      member_team [MEMBER_COUNT];
    int              team_lines  [MAX_TEAMS][$];
    int              service_order [$];
    int              queued_total;
    t_dequeue_result dequeue_results [$];

    assign o_pending = dequeue_results.size();

    task automatic clear_tables();
        for (int i = 0; i < MEMBER_COUNT; i++) member_team[i] = '0;
        for (int i = 0; i < MAX_TEAMS; i++) team_lines[i].delete();
        service_order.delete();
        queued_total = 0;
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        o_errors++;
    endtask

    task automatic predict_transfer(input t_func op, input logic [11:0] mem,
                                    input logic [9:0] team);
        int t;
        t_dequeue_result r;
        case (op)
            FUNC_ASSIGN: begin
                if (team < MAX_TEAMS) member_team[mem] = team;
            end
            FUNC_ENQUEUE: begin
                if (queued_total >= NODE_CAPACITY) begin
                    r.member = '0;
                    r.status = ST_FULL;
                    dequeue_results.push_back(r);
                end else begin
                    t = member_team[mem];
                    if (team_lines[t].size() == 0) service_order.push_back(t);
                    team_lines[t].push_back(mem);
                    queued_total++;
                end
            end
            FUNC_DEQUEUE: begin
                if (queued_total == 0) begin
                    r.member = '0;
                    r.status = ST_EMPTY;
                end else begin
                    t = service_order[0];
                    r.member = team_lines[t].pop_front();
                    r.status = ST_OK;
                    if (team_lines[t].size() == 0) void'(service_order.pop_front());
                    queued_total--;
                end
                dequeue_results.push_back(r);
            end
            default: clear_tables();
        endcase
    endtask

    initial begin
        o_errors = 0;
        clear_tables();
    end

    always @(posedge i_clk) begin
        t_dequeue_result want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (dequeue_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h/%0d", i_out_data, i_out_user));
                end else begin
                    want = dequeue_results.pop_front();
                    if (i_out_data[11:0] !== want.member)
                        report_mismatch($sformatf("member %h, want %h",
                                                  i_out_data[11:0], want.member));
                    if (i_out_data[15:12] !== 4'd0)
                        report_mismatch("nonzero pad bits in result");
                    if (i_out_user !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  i_out_user, want.status));
                end
            end
            if (i_in_valid && i_in_ready)
                predict_transfer(t_func'(i_in_user), i_in_data[11:0], i_in_data[21:12]);
        end
    end
endmodule

@@ verif/testbench.sv @@
// Testbench top for the grouped team queue: stimulus, idling, watchdog and verdict.
`timescale 1ns / 1ps
module testbench;
    import gtq_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // member_id [11:0], team [21:12], zero [23:22]
    logic [1:0]  s_axis_tuser;   // func [1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // member_out [11:0], zero [15:12]
    logic [1:0]  m_axis_tuser;   // status [1:0]

    int  error_count;
    int  pending_results;
    int  idle_cycles;
    bit  steady_phase;

    grouped_team_queue i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    team_queue_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_out_user  (m_axis_tuser),
        .o_errors    (error_count),
        .o_pending   (pending_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= steady_phase || ($urandom_range(99) >= 20);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Hold one transfer until accepted, with a random gap first outside the steady phase.
    task automatic send_item(input t_func op, input logic [11:0] mem, input logic [9:0] team);
        if (!steady_phase) begin
            while ($urandom_range(99) < 20) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {2'b00, team, mem};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
    endtask

    // Random mix of assigns, enqueues, dequeues and rare clears over the given member and team spans.
    task automatic send_random(input int member_span, input int team_span, input int enq_weight);
        int pick;
        pick = $urandom_range(99);
        if (pick < 15)
            send_item(FUNC_ASSIGN, 12'($urandom_range(member_span - 1)),
                      10'($urandom_range(team_span - 1)));
        else if (pick < 15 + enq_weight)
            send_item(FUNC_ENQUEUE, 12'($urandom_range(member_span - 1)), 10'($urandom));
        else if (pick < 99)
            send_item(FUNC_DEQUEUE, 12'($urandom), 10'($urandom));
        else
            send_item(FUNC_CLEAR, 12'($urandom), 10'($urandom));
    endtask

    initial begin
        steady_phase  = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = FUNC_ASSIGN;
        i_rst_n       = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(FUNC_DEQUEUE, 12'hfff, 10'h3ff);
        send_item(FUNC_ASSIGN, 12'hfff, 10'h3ff);
        send_item(FUNC_ASSIGN, 12'h000, 10'h001);
        send_item(FUNC_ASSIGN, 12'h555, 10'h2aa);
        send_item(FUNC_ENQUEUE, 12'h123, 10'h000);
        send_item(FUNC_ENQUEUE, 12'hfff, 10'h3ff);
        send_item(FUNC_ENQUEUE, 12'h000, 10'h000);
        send_item(FUNC_ENQUEUE, 12'h456, 10'h155);
        send_item(FUNC_ENQUEUE, 12'h555, 10'h000);
        send_item(FUNC_ENQUEUE, 12'haaa, 10'h000);
        for (int i = 0; i < 8; i++) send_item(FUNC_DEQUEUE, '0, '0);
        send_item(FUNC_ENQUEUE, 12'h777, 10'h000);
        send_item(FUNC_CLEAR, 12'hfff, 10'h3ff);
        send_item(FUNC_DEQUEUE, 12'h000, 10'h000);
        send_item(FUNC_ENQUEUE, 12'hfff, 10'h000);
        send_item(FUNC_DEQUEUE, 12'h000, 10'h000);
        drain_results();

        // Fill the node pool, overflow it, then dequeue 40 of its members.
        steady_phase = 1'b1;
        for (int i = 0; i < NODE_CAPACITY + 3; i++)
            send_item(FUNC_ENQUEUE, 12'($urandom), 10'($urandom));
        for (int i = 0; i < 40; i++)
            send_item(FUNC_DEQUEUE, 12'($urandom), 10'($urandom));
        steady_phase = 1'b0;

        for (int i = 0; i < 900; i++) begin
            if (i == 450) drain_results();
            if (i < 600) send_random(16, 4, 45);
            else send_random(4096, 1024, 40);
        end
        drain_results();
        repeat (50) @(posedge i_clk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/gtq_pkg.sv
rtl/gtq_ctrl.sv
rtl/gtq_datapath.sv
rtl/grouped_team_queue.sv
rtl/gtq_checker.sv
verif/team_queue_checker.sv
verif/testbench.sv
